// File: hw/rtl/lee_pkg.sv
// ----------------------------------------------------------------------------
// lee_pkg: shared types and constants of the line editor
// Item structs, register indexes and reset values, controller states and store sizing.
// ----------------------------------------------------------------------------
package lee_pkg;

  // Line store sizing
  localparam int LINE_DEPTH = 64;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int CNT_W      = $clog2(LINE_DEPTH + 1);

  // Register reset values
  localparam logic [7:0] ERASE_RST    = 8'd35;  // '#'
  localparam logic [7:0] KILL_RST     = 8'd64;  // '@'
  localparam logic [7:0] LINE_END_RST = 8'd10;  // LF

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ERASE    = 2'd0,
    CFG_KILL     = 2'd1,
    CFG_LINE_END = 2'd2
  } cfg_reg_t;

  // Controller states
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } lee_state_t;

  // Input item
  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [7:0] char_out;
    logic       last_of_line;
    logic       truncated;
  } out_item_t;

endpackage

// File: hw/rtl/line_editor_erase_kill.sv
// An ordinary, erase or kill item is absorbed as it is accepted; the first character
//   of a non-empty line is offered once ST_DRAIN loads it into the output register.
// Throughput: 1 input item per cycle while editing; a line drains at 1 character per
//   cycle via the store read port while out_ready is high; in_ready is low meanwhile.
// Reset: synchronous, active low; registers return to '#', '@', LF, the line
//   is empty and no item is pending. Store contents stay undefined.
// ----------------------------------------------------------------------------
// line_editor_erase_kill: line editor with erase and kill characters
// Collects characters in a stack-like store and drains the finished line.
// ----------------------------------------------------------------------------
module line_editor_erase_kill (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lee_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lee_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  lee_pkg::cfg_reg_t  cfg_index,
  input  logic [7:0]        cfg_data
);
  import lee_pkg::*;

  lee_state_t        state_r, state_nxt;
  logic [7:0]        erase_r, kill_r, line_end_r;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              drop_r, drop_nxt;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              accept;
  logic              is_flush, is_erase, is_kill;
  logic              wr_en;
  logic [7:0]        rd_data;
  logic              can_load;
  logic              rd_last;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Character classification, first match wins
  assign is_flush = in_data.end_of_input || (in_data.char_in == line_end_r);
  assign is_erase = !is_flush && (in_data.char_in == erase_r);
  assign is_kill  = !is_flush && !is_erase && (in_data.char_in == kill_r);
  assign wr_en    = accept && !is_flush && !is_erase && !is_kill &&
                    (fill_r < CNT_W'(LINE_DEPTH));

  assign can_load = !out_valid_r || out_ready;
  assign rd_last  = ({1'b0, rd_ptr_r} + CNT_W'(1)) == fill_r;

  // Store; read address follows the next pointer so data lines up with it
  lee_line_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r[ADDR_W-1:0]),
    .wr_data (in_data.char_in),
    .rd_addr (rd_ptr_nxt),
    .rd_data (rd_data)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      erase_r    <= ERASE_RST;
      kill_r     <= KILL_RST;
      line_end_r <= LINE_END_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ERASE:    erase_r    <= cfg_data;
        CFG_KILL:     kill_r     <= cfg_data;
        CFG_LINE_END: line_end_r <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_flush && (fill_r != '0)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (can_load && rd_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Line bookkeeping and output register
  always_comb begin
    fill_nxt      = fill_r;
    drop_nxt      = drop_r;
    rd_ptr_nxt    = rd_ptr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (is_flush) begin
            rd_ptr_nxt = '0;
            if (fill_r == '0) drop_nxt = 1'b0;
          end else if (is_erase) begin
            if (fill_r != '0) fill_nxt = fill_r - CNT_W'(1);
          end else if (is_kill) begin
            fill_nxt = '0;
            drop_nxt = 1'b0;
          end else if (wr_en) begin
            fill_nxt = fill_r + CNT_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (can_load) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.char_out     = rd_data;
          out_data_nxt.last_of_line = rd_last;
          out_data_nxt.truncated    = drop_r;
          if (rd_last) begin
            fill_nxt = '0;
            drop_nxt = 1'b0;
          end else begin
            rd_ptr_nxt = rd_ptr_r + ADDR_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      drop_r      <= 1'b0;
      rd_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      drop_r      <= drop_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload register
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// File: hw/rtl/lee_line_ram.sv
// ----------------------------------------------------------------------------
// lee_line_ram: line store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module lee_line_ram (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [lee_pkg::ADDR_W-1:0] wr_addr,
  input  logic [7:0]                wr_data,
  input  logic [lee_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                rd_data
);
  import lee_pkg::*;

  logic [7:0] mem [LINE_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/lee_checker.sv
// ----------------------------------------------------------------------------
// lee_checker: port-level checks of the line editor
// Watches the handshakes and the drained line over time.
// ----------------------------------------------------------------------------
module lee_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input lee_pkg::in_item_t   in_data,
  input logic               out_valid,
  input logic               out_ready,
  input lee_pkg::out_item_t  out_data,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input lee_pkg::cfg_reg_t   cfg_index,
  input logic [7:0]         cfg_data
);
  import lee_pkg::*;

  // Reset leaves nothing pending and the input open
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // Stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // A line drains without gaps, with one truncation flag throughout
  a_line_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_of_line |=>
      out_valid && (out_data.truncated == $past(out_data.truncated)))
    else $error("line drain broken or truncation flag changed");

  // Configuration port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind line_editor_erase_kill lee_checker u_lee_checker (.*);

// File: tb/line_track_pkg.sv
// ----------------------------------------------------------------------------
// line_track_pkg: expected-line tracking for the line editor testbench
// Mirrors the edit rules (line end, erase, kill, append, overflow) and keeps
// the characters that the block still owes on its result channel.
// ----------------------------------------------------------------------------
package line_track_pkg;

  import lee_pkg::*;

  class line_tracker;
    // Current control codes
    logic [7:0]  erase_code;
    logic [7:0]  kill_code;
    logic [7:0]  end_code;
    // Line being edited
    logic [7:0]  line_buf [LINE_DEPTH];
    int unsigned line_len;
    bit          overflowed;
    // Characters owed by the block, oldest first
    out_item_t   pending_chars [$];
    int          errors;

    function new();
      erase_code = ERASE_RST;
      kill_code  = KILL_RST;
      end_code   = LINE_END_RST;
      line_len   = 0;
      overflowed = 1'b0;
      errors     = 0;
    endfunction

    function void set_code(cfg_reg_t idx, logic [7:0] val);
      case (idx)
        CFG_ERASE:    erase_code = val;
        CFG_KILL:     kill_code  = val;
        CFG_LINE_END: end_code   = val;
        default: ;
      endcase
    endfunction

    // Apply one accepted input item to the line
    function void take_char(in_item_t it);
      out_item_t e;
      if (it.end_of_input || it.char_in == end_code) begin
        // line end wins over erase and kill when codes are shared
        for (int k = 0; k < line_len; k++) begin
          e.char_out     = line_buf[k];
          e.last_of_line = (k + 1 == line_len);
          e.truncated    = overflowed;
          pending_chars.push_back(e);
        end
        line_len   = 0;
        overflowed = 1'b0;
      end else if (it.char_in == erase_code) begin
        if (line_len > 0) line_len--;
      end else if (it.char_in == kill_code) begin
        line_len   = 0;
        overflowed = 1'b0;
      end else if (line_len < LINE_DEPTH) begin
        line_buf[line_len] = it.char_in;
        line_len++;
      end else begin
        overflowed = 1'b1;
      end
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction

    task report(string msg);
      if (errors < 40) $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    // Compare one emitted character with the oldest one owed
    task match_char(out_item_t got);
      out_item_t want;
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected char %02h last=%0b trunc=%0b",
                         got.char_out, got.last_of_line, got.truncated));
        return;
      end
      want = pending_chars.pop_front();
      if (got.char_out !== want.char_out)
        report($sformatf("char_out %02h, want %02h", got.char_out, want.char_out));
      if (got.last_of_line !== want.last_of_line)
        report($sformatf("last_of_line %0b, want %0b on char %02h",
                         got.last_of_line, want.last_of_line, want.char_out));
      if (got.truncated !== want.truncated)
        report($sformatf("truncated %0b, want %0b on char %02h",
                         got.truncated, want.truncated, want.char_out));
    endtask

    task check_drained();
      if (pending_chars.size() != 0)
        report($sformatf("%0d chars never emitted", pending_chars.size()));
    endtask
  endclass

endpackage

// File: tb/tb_line_editor_erase_kill.sv
// ----------------------------------------------------------------------------
// tb_line_editor_erase_kill: testbench of the line editor
// Drives directed and random character streams under several control-code
// settings, with bursty input and a stalling receiver, and checks every
// emitted character against a tracked copy of the line.
// ----------------------------------------------------------------------------
module tb_line_editor_erase_kill;

  import lee_pkg::*;
  import line_track_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS   = 6;

  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} stall_mode_t;
  typedef enum int {LINE_PLAIN, LINE_LONG, LINE_NOISE} line_kind_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  cfg_reg_t  cfg_index;
  logic [7:0] cfg_data;

  line_tracker lines = new();
  bit          hold_req;
  int          burst_left;
  int          sent_items;

  line_editor_erase_kill dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Handshake monitors: sample pre-edge values
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) lines.set_code(cfg_index, cfg_data);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) lines.take_char(in_data);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) lines.match_char(out_data);
  end

  // Offer one item; gaps between bursts of random length
  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(in_item_t'{char_in: c, end_of_input: 1'b0});
  endtask

  task automatic send_eoi(input logic [7:0] c);
    send_item(in_item_t'{char_in: c, end_of_input: 1'b1});
  endtask

  // Any byte that is none of the current control codes
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == lines.erase_code || c == lines.kill_code || c == lines.end_code);
    return c;
  endfunction

  task automatic end_line();
    if ($urandom_range(0, 3) != 0) send_char(lines.end_code);
    else send_eoi(8'($urandom_range(0, 255)));
  endtask

  // Long line; when forced it overruns the store, then erases one character and adds one
  task automatic send_long_line(input bit force_full);
    int len;
    len = force_full ? $urandom_range(LINE_DEPTH + 2, LINE_DEPTH + 8)
                     : $urandom_range(LINE_DEPTH - 4, LINE_DEPTH + 8);
    for (int i = 0; i < len; i++) begin
      if (!force_full && $urandom_range(0, 19) == 0) send_char(lines.erase_code);
      else send_char(plain_char());
    end
    if (force_full) begin
      send_char(lines.erase_code);
      send_char(plain_char());
    end
    end_line();
  endtask

  // Random lines until the item count for this phase is reached
  task automatic random_lines(input int target);
    line_kind_t kind;
    int         len;
    int         roll;
    sent_items = 0;
    while (sent_items < target) begin
      roll = $urandom_range(0, 29);
      kind = (roll == 0) ? LINE_LONG : (roll < 5) ? LINE_NOISE : LINE_PLAIN;
      case (kind)
        LINE_LONG: send_long_line(1'b0);
        LINE_NOISE: begin
          len = $urandom_range(1, 8);
          repeat (len)
            send_item(in_item_t'{char_in: 8'($urandom_range(0, 255)),
                                 end_of_input: ($urandom_range(0, 7) == 0)});
        end
        default: begin
          len = $urandom_range(0, 10);
          repeat (len) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) send_char(lines.erase_code);
            else if (roll < 11) send_char(lines.kill_code);
            else send_char(plain_char());
          end
          end_line();
        end
      endcase
    end
  endtask

  // Wait until every owed character is out, then let the block settle
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lines.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three control codes; only called while the block is idle
  task automatic set_codes(input logic [7:0] erase_v, input logic [7:0] kill_v,
                           input logic [7:0] end_v);
    cfg_reg_t   regs [3] = '{CFG_ERASE, CFG_KILL, CFG_LINE_END};
    logic [7:0] vals [3];
    vals = '{erase_v, kill_v, end_v};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Receiver: stall pattern changes after a span of random length; long hold on request
  initial begin
    stall_mode_t mode;
    int          span;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 64);
      repeat (span) begin
        if (hold_req) begin
          hold_req = 1'b0;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ($urandom_range(0, 9) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Stimulus
  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_ERASE;
    cfg_data   <= '0;
    hold_req   = 1'b0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset codes: erase mid-line
    send_char("a"); send_char("b"); send_char("#"); send_char("c"); send_char(8'h0a);
    // erase on an empty line is ignored
    send_char("#"); send_char("#"); send_char("x"); send_char(8'h0a);
    // kill drops the line so far
    send_char("p"); send_char("q"); send_char("@"); send_char("r"); send_char(8'h0a);
    // empty lines emit nothing; end of input ignores its character
    send_char(8'h0a);
    send_eoi("z");
    // byte extremes flushed by end of input, then editing goes on
    send_char(8'h00); send_char(8'hff); send_eoi(8'hff);
    send_char("k"); send_char(8'h0a);

    // Store overflow, with an erase after the drop
    send_long_line(1'b1);
    random_lines(PHASE_ITEMS);
    drain_and_settle();

    // Receiver holds off while lines keep coming; a non-empty line fills it
    set_codes(8'h00, 8'hff, 8'h7f);
    hold_req = 1'b1;
    send_char(plain_char());
    send_char(lines.end_code);
    random_lines(PHASE_ITEMS);
    drain_and_settle();

    // Erase shares the line end code: line end wins
    set_codes(8'hff, 8'h00, 8'hff);
    random_lines(PHASE_ITEMS);
    drain_and_settle();

    // Kill shares the erase code: erase wins; line end at zero
    set_codes(8'h41, 8'h41, 8'h00);
    random_lines(PHASE_ITEMS);
    drain_and_settle();

    set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
    random_lines(PHASE_ITEMS);
    drain_and_settle();

    set_codes(ERASE_RST, KILL_RST, LINE_END_RST);
    random_lines(PHASE_ITEMS);
    drain_and_settle();

    lines.check_drained();
    if (lines.errors == 0) begin
      $display("tb_line_editor_erase_kill passed");
    end else begin
      $display("tb_line_editor_erase_kill failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("tb_line_editor_erase_kill failed");
    $finish;
  end

endmodule
